// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the spline evaluator.
// Depends on nothing; include with the bare file name before the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset
`define PCSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge outside reset
`define PCSE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define PCSE_ASSERT(lbl, clk, rstn, prop, msg)
`define PCSE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/pcse_pkg.sv =====
// Types and constants of the piecewise cubic spline evaluator.
// No dependencies; used by piecewise_cubic_spline_eval.
package pcse_pkg;

  // Input stream packing (tdata, lowest bit first)
  localparam int SEG_INDEX_W  = 4;
  localparam int Q_W          = 32;
  localparam int OFS_SEG      = 0;
  localparam int OFS_LEFT     = OFS_SEG + SEG_INDEX_W;
  localparam int OFS_RIGHT    = OFS_LEFT + Q_W;
  localparam int OFS_CUBIC    = OFS_RIGHT + Q_W;
  localparam int OFS_SQUARE   = OFS_CUBIC + Q_W;
  localparam int OFS_LINEAR   = OFS_SQUARE + Q_W;
  localparam int OFS_CONST    = OFS_LINEAR + Q_W;
  localparam int OFS_X        = OFS_CONST + Q_W;
  localparam int IN_FIELDS_W  = OFS_X + Q_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = Q_W;
  localparam int OUT_TUSER_W  = 2;
  localparam int TUSER_EMPTY  = 0;
  localparam int TUSER_SAT    = 1;

  // Item kinds carried in in_tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_SEGMENT_COUNT = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_ENABLE  = 4'd1;
  localparam int SEG_COUNT_W = 5;

  // Datapath widths
  localparam int FRAC_W     = 16;
  localparam int DX_W       = 33;
  localparam int PROD_W     = 48;
  localparam int DIGIT_W    = 11;
  localparam int NUM_DIGITS = 3;
  localparam int DIG_CNT_W  = 2;
  localparam int ACC_W      = PROD_W + DX_W;
  localparam int SUM_W      = 51;
  localparam logic [PROD_W-1:0] GUARD_MAG = 48'h7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_Y_MAX = 51'sh0_0000_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_Y_MIN = -51'sh0_0000_8000_0000;
  localparam logic [Q_W-1:0] Y_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Y_MIN = 32'h8000_0000;

  // One segment of the table
  typedef struct packed {
    logic signed [Q_W-1:0] left_bound;
    logic signed [Q_W-1:0] right_bound;
    logic signed [Q_W-1:0] cubic_coef;
    logic signed [Q_W-1:0] square_coef;
    logic signed [Q_W-1:0] linear_coef;
    logic signed [Q_W-1:0] constant_coef;
  } seg_entry_t;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LB    = 9'b000000010,
    ST_RB    = 9'b000000100,
    ST_SCAN  = 9'b000001000,
    ST_FETCH = 9'b000010000,
    ST_PREP  = 9'b000100000,
    ST_MUL   = 9'b001000000,
    ST_ACC   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  // Multiplication steps of the polynomial
  typedef enum logic [2:0] {
    OP_CUBE1 = 3'd0,
    OP_CUBE2 = 3'd1,
    OP_CUBE3 = 3'd2,
    OP_SQR1  = 3'd3,
    OP_SQR2  = 3'd4,
    OP_LIN   = 3'd5
  } op_t;

endpackage

// ===== rtl/piecewise_cubic_spline_eval.sv =====
// Piecewise cubic spline evaluator, Q16.16, top level.
// Depends on pcse_pkg and assert_macros.svh.
//
// Channel  Dir  Handshake               Payload
// in_      in   in_tvalid/in_tready     tdata: segment load or x, tuser: kind
// out_     out  out_tvalid/out_tready   tdata: y_value, tuser: flags
// cfg_     in   cfg_valid/cfg_ready     cfg_addr: register index, cfg_wdata
//
// A load completes in the idle state. An evaluate reads the first left bound
// and the last right bound, then scans k = 1..n segments (one table read per
// cycle) and re-reads the first entry when x falls below the table; the six
// Q16.16 products share one 48x11 multiplier, taking |dx| in three 11-bit digits.
// An empty table skips to the final step. in_tready is high only when idle.
// A result waits in the output register until taken; the block stalls in its
// final step only if a second result finishes before the first is taken.
// Reset (rst_n, synchronous) clears control; table contents stay undefined.
`include "assert_macros.svh"

module piecewise_cubic_spline_eval #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: seg_index, left_bound, right_bound, cubic_coef, square_coef,
  //           linear_coef, constant_coef, x_value, zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pcse_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tuser,     // kind
  // out_tdata: y_value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [pcse_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [pcse_pkg::OUT_TUSER_W-1:0]     out_tuser,    // table_empty, saturated
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcse_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [31:0]                          cfg_wdata
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [8:0] MAX9 = 9'(MAX_SEGMENTS);

  // Configuration registers
  logic [pcse_pkg::SEG_COUNT_W-1:0] seg_cnt_r;
  logic                             clamp_r;

  // Table memory
  pcse_pkg::seg_entry_t seg_mem [MAX_SEGMENTS];
  pcse_pkg::seg_entry_t rd_data_r;
  pcse_pkg::seg_entry_t wr_entry;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 wr_en;

  // Sequencer and datapath
  pcse_pkg::state_t state_r, state_nxt;
  pcse_pkg::op_t    op_r, op_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    last_r, last_nxt;
  logic [pcse_pkg::DIG_CNT_W-1:0] dig_r, dig_nxt;
  logic signed [pcse_pkg::Q_W-1:0]    x_r, x_nxt;
  logic signed [pcse_pkg::Q_W-1:0]    left0_r, left0_nxt;
  logic signed [pcse_pkg::Q_W-1:0]    b_r, b_nxt;
  logic signed [pcse_pkg::Q_W-1:0]    c_r, c_nxt;
  logic signed [pcse_pkg::PROD_W-1:0] p_r, p_nxt;
  logic [pcse_pkg::PROD_W-1:0]        mp_r, mp_nxt;
  logic                               neg_r, neg_nxt;
  logic [pcse_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic [pcse_pkg::DX_W-1:0]          dqm_r, dqm_nxt;
  logic                               dxn_r, dxn_nxt;
  logic signed [pcse_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic                               empty_r, empty_nxt;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic [pcse_pkg::Q_W-1:0]           y_r, y_nxt;
  logic                               empty_o_r, empty_o_nxt;
  logic                               sat_o_r, sat_o_nxt;

  // Input field views
  logic [pcse_pkg::SEG_INDEX_W-1:0]   in_seg;
  logic signed [pcse_pkg::Q_W-1:0]    in_x;
  logic                               in_accept;
  logic                               seg_ok;

  // Shared helpers
  logic [8:0]                         cnt9, n9;
  logic [AW-1:0]                      last_addr;
  logic signed [pcse_pkg::Q_W-1:0]    x_lo, x_cl;
  logic                               hit, at_last;
  logic signed [pcse_pkg::DX_W-1:0]   dx_s;
  logic [pcse_pkg::DIGIT_W-1:0]       digit;
  logic [pcse_pkg::PROD_W+pcse_pkg::DIGIT_W-1:0] partial;
  logic [pcse_pkg::ACC_W-pcse_pkg::FRAC_W-1:0]   mag_full;
  logic [pcse_pkg::PROD_W-1:0]        mag_sat;
  logic signed [pcse_pkg::PROD_W-1:0] term;
  logic signed [pcse_pkg::SUM_W-1:0]  sum_term;

  assign in_seg    = in_tdata[pcse_pkg::OFS_SEG +: pcse_pkg::SEG_INDEX_W];
  assign in_x      = in_tdata[pcse_pkg::OFS_X +: pcse_pkg::Q_W];
  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == pcse_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = y_r;
  assign out_tuser  = {sat_o_r, empty_o_r};

  // Effective segment count, capped at the table depth
  assign cnt9      = 9'(seg_cnt_r);
  assign n9        = (cnt9 > MAX9) ? MAX9 : cnt9;
  assign last_addr = AW'(n9 - 9'd1);

  // Load entry from the input stream
  assign seg_ok  = (9'(in_seg) < MAX9);
  assign wr_addr = AW'(in_seg);
  assign wr_en   = in_accept && (in_tuser == pcse_pkg::KIND_LOAD) && seg_ok;
  assign wr_entry.left_bound    = in_tdata[pcse_pkg::OFS_LEFT +: pcse_pkg::Q_W];
  assign wr_entry.right_bound   = in_tdata[pcse_pkg::OFS_RIGHT +: pcse_pkg::Q_W];
  assign wr_entry.cubic_coef    = in_tdata[pcse_pkg::OFS_CUBIC +: pcse_pkg::Q_W];
  assign wr_entry.square_coef   = in_tdata[pcse_pkg::OFS_SQUARE +: pcse_pkg::Q_W];
  assign wr_entry.linear_coef   = in_tdata[pcse_pkg::OFS_LINEAR +: pcse_pkg::Q_W];
  assign wr_entry.constant_coef = in_tdata[pcse_pkg::OFS_CONST +: pcse_pkg::Q_W];

  // Clamp x: raise to the first left bound, then lower to the last right bound
  assign x_lo = (clamp_r && (x_r < left0_r)) ? left0_r : x_r;
  assign x_cl = (clamp_r && (x_lo > rd_data_r.right_bound)) ? rd_data_r.right_bound : x_lo;

  // Scan compare against the entry just read
  assign hit     = (x_r >= rd_data_r.left_bound) && (x_r <= rd_data_r.right_bound);
  assign at_last = (idx_r == last_r);
  assign dx_s    = {x_r[pcse_pkg::Q_W-1], x_r} -
                   {rd_data_r.left_bound[pcse_pkg::Q_W-1], rd_data_r.left_bound};

  // Shared multiplier: one 11-bit digit of |dx| per cycle
  assign digit   = pcse_pkg::DIGIT_W'(dqm_r >> (pcse_pkg::DIGIT_W * dig_r));
  assign partial = mp_r * digit;

  // Product magnitude after the Q16 shift, saturated, then signed
  assign mag_full = acc_r[pcse_pkg::ACC_W-1:pcse_pkg::FRAC_W];
  assign mag_sat  = (mag_full > (pcse_pkg::ACC_W - pcse_pkg::FRAC_W)'(pcse_pkg::GUARD_MAG))
                    ? pcse_pkg::GUARD_MAG : mag_full[pcse_pkg::PROD_W-1:0];
  assign term     = neg_r ? -$signed(mag_sat) : $signed(mag_sat);
  assign sum_term = sum_r + pcse_pkg::SUM_W'(term);

  // Read address per state
  always_comb begin
    case (state_r)
      pcse_pkg::ST_LB:   rd_addr = last_r;
      pcse_pkg::ST_SCAN: rd_addr = at_last ? '0 : AW'(idx_r + 1'b1);
      default:           rd_addr = '0;
    endcase
  end

  // Sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    dig_nxt       = dig_r;
    x_nxt         = x_r;
    left0_nxt     = left0_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    p_nxt         = p_r;
    mp_nxt        = mp_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    dqm_nxt       = dqm_r;
    dxn_nxt       = dxn_r;
    sum_nxt       = sum_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && !out_tready;
    y_nxt         = y_r;
    empty_o_nxt   = empty_o_r;
    sat_o_nxt     = sat_o_r;

    case (state_r)
      pcse_pkg::ST_IDLE: begin
        // Start an evaluate transaction; loads finish here
        if (in_accept && (in_tuser == pcse_pkg::KIND_EVAL)) begin
          x_nxt    = in_x;
          last_nxt = last_addr;
          if (n9 == 9'd0) begin
            empty_nxt = 1'b1;
            state_nxt = pcse_pkg::ST_DONE;
          end else begin
            empty_nxt = 1'b0;
            state_nxt = pcse_pkg::ST_LB;
          end
        end
      end
      pcse_pkg::ST_LB: begin
        left0_nxt = rd_data_r.left_bound;
        state_nxt = pcse_pkg::ST_RB;
      end
      pcse_pkg::ST_RB: begin
        x_nxt     = x_cl;
        idx_nxt   = '0;
        state_nxt = pcse_pkg::ST_SCAN;
      end
      pcse_pkg::ST_SCAN: begin
        // Take the first hit, or fall back to the last entry above the span
        if (hit || (at_last && !(x_r < left0_r))) begin
          state_nxt = pcse_pkg::ST_PREP;
        end else if (at_last) begin
          state_nxt = pcse_pkg::ST_FETCH;
        end else begin
          idx_nxt = AW'(idx_r + 1'b1);
        end
      end
      pcse_pkg::ST_FETCH: begin
        state_nxt = pcse_pkg::ST_PREP;
      end
      pcse_pkg::ST_PREP: begin
        mp_nxt    = p_r[pcse_pkg::PROD_W-1] ? pcse_pkg::PROD_W'(-p_r) : pcse_pkg::PROD_W'(p_r);
        neg_nxt   = p_r[pcse_pkg::PROD_W-1] ^ dxn_r;
        acc_nxt   = '0;
        dig_nxt   = '0;
        state_nxt = pcse_pkg::ST_MUL;
      end
      pcse_pkg::ST_MUL: begin
        acc_nxt = acc_r + (pcse_pkg::ACC_W'(partial) << (pcse_pkg::DIGIT_W * dig_r));
        if (dig_r == pcse_pkg::DIG_CNT_W'(pcse_pkg::NUM_DIGITS - 1)) begin
          state_nxt = pcse_pkg::ST_ACC;
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      pcse_pkg::ST_ACC: begin
        // Route the product to the next step or into the sum
        state_nxt = pcse_pkg::ST_PREP;
        case (op_r)
          pcse_pkg::OP_CUBE1: begin
            p_nxt  = term;
            op_nxt = pcse_pkg::OP_CUBE2;
          end
          pcse_pkg::OP_CUBE2: begin
            p_nxt  = term;
            op_nxt = pcse_pkg::OP_CUBE3;
          end
          pcse_pkg::OP_CUBE3: begin
            sum_nxt = sum_term;
            p_nxt   = pcse_pkg::PROD_W'(b_r);
            op_nxt  = pcse_pkg::OP_SQR1;
          end
          pcse_pkg::OP_SQR1: begin
            p_nxt  = term;
            op_nxt = pcse_pkg::OP_SQR2;
          end
          pcse_pkg::OP_SQR2: begin
            sum_nxt = sum_term;
            p_nxt   = pcse_pkg::PROD_W'(c_r);
            op_nxt  = pcse_pkg::OP_LIN;
          end
          pcse_pkg::OP_LIN: begin
            sum_nxt   = sum_term;
            state_nxt = pcse_pkg::ST_DONE;
          end
          default: begin
            state_nxt = pcse_pkg::ST_DONE;
          end
        endcase
      end
      pcse_pkg::ST_DONE: begin
        // Hold until the output register is free, then saturate and present
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          empty_o_nxt   = empty_r;
          if (empty_r) begin
            y_nxt     = '0;
            sat_o_nxt = 1'b0;
          end else if (sum_r > pcse_pkg::SUM_Y_MAX) begin
            y_nxt     = pcse_pkg::Y_MAX;
            sat_o_nxt = 1'b1;
          end else if (sum_r < pcse_pkg::SUM_Y_MIN) begin
            y_nxt     = pcse_pkg::Y_MIN;
            sat_o_nxt = 1'b1;
          end else begin
            y_nxt     = sum_r[pcse_pkg::Q_W-1:0];
            sat_o_nxt = 1'b0;
          end
          state_nxt = pcse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcse_pkg::ST_IDLE;
      end
    endcase

    // Latch the chosen segment from the entry just read
    if (((state_r == pcse_pkg::ST_SCAN) && (hit || (at_last && !(x_r < left0_r)))) ||
        (state_r == pcse_pkg::ST_FETCH)) begin
      p_nxt   = pcse_pkg::PROD_W'(rd_data_r.cubic_coef);
      b_nxt   = rd_data_r.square_coef;
      c_nxt   = rd_data_r.linear_coef;
      sum_nxt = pcse_pkg::SUM_W'(rd_data_r.constant_coef);
      dxn_nxt = dx_s[pcse_pkg::DX_W-1];
      dqm_nxt = dx_s[pcse_pkg::DX_W-1] ? pcse_pkg::DX_W'(-dx_s) : pcse_pkg::DX_W'(dx_s);
      op_nxt  = pcse_pkg::OP_CUBE1;
    end
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[wr_addr] <= wr_entry;
    end
    rd_data_r <= seg_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcse_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      seg_cnt_r   <= '0;
      clamp_r     <= 1'b1;
      dig_r       <= '0;
      idx_r       <= '0;
      op_r        <= pcse_pkg::OP_CUBE1;
      last_r      <= '0;
      empty_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dig_r       <= dig_nxt;
      idx_r       <= idx_nxt;
      op_r        <= op_nxt;
      last_r      <= last_nxt;
      empty_r     <= empty_nxt;
      // Take configuration writes; unknown indexes drop
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == pcse_pkg::REG_SEGMENT_COUNT) begin
          seg_cnt_r <= cfg_wdata[pcse_pkg::SEG_COUNT_W-1:0];
        end else if (cfg_addr == pcse_pkg::REG_CLAMP_ENABLE) begin
          clamp_r <= cfg_wdata[0];
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    left0_r   <= left0_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
    p_r       <= p_nxt;
    mp_r      <= mp_nxt;
    neg_r     <= neg_nxt;
    acc_r     <= acc_nxt;
    dqm_r     <= dqm_nxt;
    dxn_r     <= dxn_nxt;
    sum_r     <= sum_nxt;
    y_r       <= y_nxt;
    empty_o_r <= empty_o_nxt;
    sat_o_r   <= sat_o_nxt;
  end

  // Assertions
  `PCSE_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == pcse_pkg::ST_DONE), "result appeared outside final step")
  `PCSE_ASSERT(a_empty_zero, clk, rst_n, (out_valid_r && empty_o_r) |-> (y_r == '0 && !sat_o_r), "empty table result not zero")
  `PCSE_ASSERT(a_sat_rails, clk, rst_n, (out_valid_r && sat_o_r) |-> (y_r == pcse_pkg::Y_MAX || y_r == pcse_pkg::Y_MIN), "saturated result off the rails")
  `PCSE_ASSERT(a_scan_bound, clk, rst_n, (state_r == pcse_pkg::ST_SCAN) |-> (idx_r <= last_r), "scan index past last segment")
  `PCSE_ASSERT_NEVER(a_digit_range, clk, rst_n, (state_r == pcse_pkg::ST_MUL) && (dig_r >= pcse_pkg::DIG_CNT_W'(pcse_pkg::NUM_DIGITS)), "multiplier digit out of range")

endmodule

// ===== tb/sv/piecewise_cubic_spline_eval_tb.sv =====
// Self-checking testbench for the piecewise cubic spline evaluator.
// Holds a Q16.16 predictor of the segment table, queue-fed stream driver and monitor.
// Depends on pcse_pkg and the piecewise_cubic_spline_eval RTL.
`timescale 1ns / 100ps

module piecewise_cubic_spline_eval_tb;
  import pcse_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 900;
  localparam int PAD_W = IN_TDATA_W - IN_FIELDS_W;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_NEG_MAX = 32'sh8000_0000;

  typedef struct {
    logic               kind;
    logic [3:0]         seg_index;
    logic signed [31:0] left_bound;
    logic signed [31:0] right_bound;
    logic signed [31:0] cubic_coef;
    logic signed [31:0] square_coef;
    logic signed [31:0] linear_coef;
    logic signed [31:0] constant_coef;
    logic signed [31:0] x_value;
  } spline_item_t;

  typedef struct packed {
    logic [31:0] y_value;
    logic        table_empty;
    logic        saturated;
  } spline_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // Stimulus and expected results
  spline_item_t pending_items[$];
  spline_item_t cur_item;
  spline_result_t expected_results[$];

  // Predictor copy of the segment table and registers
  logic signed [31:0] seg_left[TABLE_DEPTH];
  logic signed [31:0] seg_right[TABLE_DEPTH];
  logic signed [31:0] seg_cubic[TABLE_DEPTH];
  logic signed [31:0] seg_square[TABLE_DEPTH];
  logic signed [31:0] seg_linear[TABLE_DEPTH];
  logic signed [31:0] seg_const[TABLE_DEPTH];
  logic [SEG_COUNT_W-1:0] seg_count_q = '0;
  logic clamp_q = 1'b1;

  // Bounds as queued, used to aim evaluation points
  logic signed [31:0] plan_left[TABLE_DEPTH];
  logic signed [31:0] plan_right[TABLE_DEPTH];

  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int items_queued = 0;
  int loads_taken = 0;
  int evals_checked = 0;
  int sat_seen = 0;
  int empty_seen = 0;
  int phase_count = 0;

  piecewise_cubic_spline_eval #(.MAX_SEGMENTS(TABLE_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q16.16 product, truncated toward zero, held to +-(2^47 - 1)
  function automatic longint q16_mul(longint p, longint q);
    longint unsigned mp, mq, hi, mag;
    mp = (p < 0) ? -p : p;
    mq = (q < 0) ? -q : q;
    hi = mp * (mq >> FRAC_W);
    if (hi > GUARD_MAG) begin
      mag = GUARD_MAG;
    end else begin
      mag = hi + ((mp * (mq & 64'hFFFF)) >> FRAC_W);
      if (mag > GUARD_MAG) mag = GUARD_MAG;
    end
    if ((p < 0) != (q < 0)) return -longint'(mag);
    return longint'(mag);
  endfunction

  // Evaluate the spline at x from the predictor's table and registers
  function automatic spline_result_t predict_spline(logic signed [31:0] x_in);
    int n;
    int pick;
    bit found;
    longint x, dx, sum;
    spline_result_t res;
    res = '0;
    n = (seg_count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(seg_count_q);
    if (n == 0) begin
      res.table_empty = 1'b1;
      return res;
    end
    x = x_in;
    if (clamp_q) begin
      if (x < seg_left[0]) x = seg_left[0];
      if (x > seg_right[n-1]) x = seg_right[n-1];
    end
    found = 1'b0;
    pick = 0;
    for (int i = 0; i < n && !found; i++) begin
      if (x >= seg_left[i] && x <= seg_right[i]) begin
        pick = i;
        found = 1'b1;
      end
    end
    // Fall back to an end segment when no interval holds x
    if (!found) pick = (x < seg_left[0]) ? 0 : n - 1;
    dx = x - longint'(seg_left[pick]);
    sum = q16_mul(q16_mul(q16_mul(seg_cubic[pick], dx), dx), dx)
        + q16_mul(q16_mul(seg_square[pick], dx), dx)
        + q16_mul(seg_linear[pick], dx)
        + longint'(seg_const[pick]);
    if (sum > 64'sd2147483647) begin
      res.y_value = Q_POS_MAX;
      res.saturated = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      res.y_value = Q_NEG_MAX;
      res.saturated = 1'b1;
    end else begin
      res.y_value = sum[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic int rand_span(int unsigned m);
    return int'($urandom_range(2 * m)) - int'(m);
  endfunction

  function automatic spline_item_t random_item();
    spline_item_t it;
    it.kind = $urandom_range(1);
    it.seg_index = $urandom_range(15);
    it.left_bound = $urandom();
    it.right_bound = $urandom();
    it.cubic_coef = $urandom();
    it.square_coef = $urandom();
    it.linear_coef = $urandom();
    it.constant_coef = $urandom();
    it.x_value = $urandom();
    return it;
  endfunction

  task automatic push_load(logic [3:0] idx, logic signed [31:0] l, logic signed [31:0] r,
                           logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] c, logic signed [31:0] d);
    spline_item_t it;
    it = random_item();
    it.kind = KIND_LOAD;
    it.seg_index = idx;
    it.left_bound = l;
    it.right_bound = r;
    it.cubic_coef = a;
    it.square_coef = b;
    it.linear_coef = c;
    it.constant_coef = d;
    pending_items.push_back(it);
    plan_left[idx] = l;
    plan_right[idx] = r;
    items_queued++;
  endtask

  task automatic push_eval(logic signed [31:0] x);
    spline_item_t it;
    it = random_item();
    it.kind = KIND_EVAL;
    it.x_value = x;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Load a fully random entry
  task automatic push_noise_load(logic [3:0] idx);
    push_load(idx, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  // Queue a full table in ascending left bound: knots, gaps and overlaps
  task automatic queue_smooth_table();
    longint knot_pos;
    int unsigned w;
    logic signed [31:0] l, r, a, b, c, d;
    knot_pos = rand_span(1 << 22);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      w = $urandom_range(1 << 18, 1);
      l = knot_pos;
      r = knot_pos + w;
      if ($urandom_range(7) == 0) begin
        a = $urandom();
        b = $urandom();
        c = $urandom();
        d = $urandom();
      end else begin
        a = rand_span(1 << 17);
        b = rand_span(1 << 18);
        c = rand_span(1 << 20);
        d = rand_span(1 << 24);
      end
      push_load(i, l, r, a, b, c, d);
      case ($urandom_range(3))
        1: knot_pos = r + $urandom_range(1 << 16, 1);
        2: knot_pos = r - (w / 2);
        default: knot_pos = r;
      endcase
    end
  endtask

  // Aim an evaluation point at the segments in use, the span ends or anywhere
  task automatic queue_eval_point(int n);
    int k, pick;
    longint lo, hi, x;
    k = $urandom_range(n - 1);
    lo = plan_left[k];
    hi = plan_right[k];
    pick = $urandom_range(99);
    if (pick < 40) begin
      x = (hi >= lo) ? lo + (longint'($urandom()) % (hi - lo + 1)) : lo;
    end else if (pick < 55) begin
      x = $urandom_range(1) ? lo : hi;
    end else if (pick < 65) begin
      x = $urandom_range(1) ? longint'(plan_left[0]) - $urandom_range(1 << 18, 1)
                            : longint'(Q_NEG_MAX);
    end else if (pick < 75) begin
      x = $urandom_range(1) ? longint'(plan_right[n-1]) + $urandom_range(1 << 18, 1)
                            : longint'(Q_POS_MAX);
    end else begin
      x = longint'($signed($urandom()));
    end
    if (x > Q_POS_MAX) x = Q_POS_MAX;
    if (x < Q_NEG_MAX) x = Q_NEG_MAX;
    push_eval(x[31:0]);
  endtask

  // Write one register; call only while the block is idle
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (addr == REG_SEGMENT_COUNT) seg_count_q = data[SEG_COUNT_W-1:0];
    else if (addr == REG_CLAMP_ENABLE) clamp_q = data[0];
    @(posedge clk);
  endtask

  // Wait until every queued transaction is taken and every result has arrived
  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    phase_count++;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1: begin sender_idle_pct = 57; sink_stall_pct = 0; end
      2: begin sender_idle_pct = 0; sink_stall_pct = 57; end
      3: begin sender_idle_pct = 19; sink_stall_pct = 19; end
      default: begin sender_idle_pct = 0; sink_stall_pct = 0; end
    endcase
  endtask

  // Drive input transactions from the pending queue; predict at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_item.kind == KIND_LOAD) begin
          seg_left[cur_item.seg_index] = cur_item.left_bound;
          seg_right[cur_item.seg_index] = cur_item.right_bound;
          seg_cubic[cur_item.seg_index] = cur_item.cubic_coef;
          seg_square[cur_item.seg_index] = cur_item.square_coef;
          seg_linear[cur_item.seg_index] = cur_item.linear_coef;
          seg_const[cur_item.seg_index] = cur_item.constant_coef;
          loads_taken++;
        end else begin
          expected_results.push_back(predict_spline(cur_item.x_value));
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_item.kind;
          in_tdata <= {{PAD_W{1'b0}}, cur_item.x_value, cur_item.constant_coef,
                       cur_item.linear_coef, cur_item.square_coef, cur_item.cubic_coef,
                       cur_item.right_bound, cur_item.left_bound, cur_item.seg_index};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel at random and check each result transaction
  always @(posedge clk) begin
    spline_result_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result y=%h flags=%b", out_tdata, out_tuser));
        end else begin
          exp_res = expected_results.pop_front();
          evals_checked++;
          if (exp_res.saturated) sat_seen++;
          if (exp_res.table_empty) empty_seen++;
          if (out_tdata !== exp_res.y_value)
            report_mismatch($sformatf("y_value %h, predicted %h", out_tdata, exp_res.y_value));
          if (out_tuser[TUSER_EMPTY] !== exp_res.table_empty)
            report_mismatch($sformatf("table_empty %b, predicted %b",
                                      out_tuser[TUSER_EMPTY], exp_res.table_empty));
          if (out_tuser[TUSER_SAT] !== exp_res.saturated)
            report_mismatch($sformatf("saturated %b, predicted %b",
                                      out_tuser[TUSER_SAT], exp_res.saturated));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int round, n, cnt, style;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table after reset
    set_idling(0);
    push_eval(32'sh0);
    push_eval(Q_NEG_MAX);
    drain();

    // Small table: shared knot, a gap, extreme coefficients, extreme last index
    push_load(4'd0, -Q_ONE, 32'sh0, 32'sh0, 32'sh0, Q_ONE, 32'sh0);
    push_load(4'd1, 32'sh0, Q_ONE, 32'sh0000_4000, -32'sh0000_8000, 32'sh0, Q_ONE);
    push_load(4'd2, 2 * Q_ONE, 3 * Q_ONE, Q_ONE, -Q_ONE, 32'sh0000_8000, Q_NEG_MAX);
    push_load(4'd3, 3 * Q_ONE, 4 * Q_ONE, Q_NEG_MAX, Q_POS_MAX, Q_NEG_MAX, Q_POS_MAX);
    push_load(4'd15, Q_NEG_MAX, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX);
    drain();
    write_reg(REG_SEGMENT_COUNT, 32'd4);
    write_reg(REG_CLAMP_ENABLE, 32'd1);
    push_eval(Q_NEG_MAX);
    push_eval(Q_POS_MAX);
    push_eval(32'sh0);
    push_eval(32'sh0001_8000);
    push_eval(-32'sh0000_8000);
    push_eval(32'sh0003_8000);
    drain();

    // Unclamped: far outside the span, in the gap, on the first bound
    write_reg(REG_CLAMP_ENABLE, 32'd0);
    push_eval(Q_NEG_MAX);
    push_eval(Q_POS_MAX);
    push_eval(32'sh0001_8000);
    push_eval(-Q_ONE);
    drain();

    // Crossed span: last right bound below first left bound, upper clamp wins
    push_load(4'd1, 5 * Q_ONE, -3 * Q_ONE, 32'sh0000_4000, -32'sh0000_8000, 32'sh0, Q_ONE);
    drain();
    write_reg(REG_SEGMENT_COUNT, 32'd2);
    write_reg(REG_CLAMP_ENABLE, 32'd1);
    push_eval(32'sh0);
    push_eval(Q_NEG_MAX);
    drain();

    // Random phases: new settings, table reloads and aimed evaluations
    round = 0;
    while (items_queued < RANDOM_ITEMS + 20) begin
      set_idling(round % 4);
      case ($urandom_range(9))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = TABLE_DEPTH;
        3: cnt = $urandom_range(31, TABLE_DEPTH + 1);
        default: cnt = $urandom_range(TABLE_DEPTH - 1, 2);
      endcase
      write_reg(REG_SEGMENT_COUNT, ($urandom() & ~32'h1F) | cnt);
      write_reg(REG_CLAMP_ENABLE, ($urandom() & ~32'h1) | $urandom_range(1));
      n = (cnt == 0 || cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
      style = $urandom_range(99);
      if (round == 0 || style < 60) begin
        queue_smooth_table();
      end else if (style < 85) begin
        repeat ($urandom_range(4, 1)) push_noise_load($urandom_range(15));
      end else begin
        for (int i = 0; i < TABLE_DEPTH; i++) push_noise_load(i);
      end
      repeat (30) begin
        if ($urandom_range(14) == 0) push_noise_load($urandom_range(15));
        else queue_eval_point(n);
      end
      drain();
      round++;
    end

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Covered %0d loads and %0d evaluations over %0d phases",
             loads_taken, evals_checked, phase_count);
    $display("  %0d saturated, %0d on an empty table, %0d mismatches",
             sat_seen, empty_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
